// File: design/pqe_pkg.sv
// ----------------------------------------------------------------------------
// pqe_pkg
// Shared types and constants of the uniform PCM quantiser and serial encoder.
// ----------------------------------------------------------------------------
package pqe_pkg;

    localparam int LVL_W     = 16;
    localparam int AMP_W     = 15;
    localparam int LC_W      = 17;
    localparam int BC_W      = 5;
    localparam int DEN_W     = 16;
    localparam int PROD_W    = LC_W + DEN_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = LVL_W / DIV_STAGES;

    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT   = 2'd2;

    localparam logic [AMP_W-1:0] AMP_RESET = 15'd32767;
    localparam logic [LC_W-1:0]  LC_RESET  = 17'd256;
    localparam logic [BC_W-1:0]  BC_RESET  = 5'd8;

    localparam logic [LC_W-1:0]  LC_MIN = 17'd2;
    localparam logic [LC_W-1:0]  LC_MAX = 17'd65536;

    // one request in flight through the divider
    typedef struct packed {
        logic             hi;
        logic             lo;
        logic [DEN_W-1:0] rem;
        logic [LVL_W-1:0] num;
        logic [LVL_W-1:0] quo;
    } t_div;

endpackage

// File: design/pqe_front.sv
// ----------------------------------------------------------------------------
// pqe_front
// Range check, offset by amplitude and scaling by the level count.
// ----------------------------------------------------------------------------
module pqe_front
    import pqe_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [AMP_W-1:0]        i_amp,
    input  logic [LC_W-1:0]         i_lc,
    output logic                    o_valid,
    output t_div                    o_div
);

    localparam int CMP_W = ((SAMPLE_WIDTH > DEN_W) ? SAMPLE_WIDTH : DEN_W) + 1;

    logic [CMP_W-1:0]  s_ext;
    logic [CMP_W-1:0]  a_ext;
    logic [CMP_W-1:0]  sum;
    logic [CMP_W-1:0]  diff;
    logic              hi;
    logic              lo;
    logic [PROD_W-1:0] prod;

    logic              r_s1_valid;
    logic              r_s1_hi;
    logic              r_s1_lo;
    logic [DEN_W-1:0]  r_s1_sum;
    logic              r_s2_valid;
    t_div              r_s2;

    assign s_ext = {{(CMP_W-SAMPLE_WIDTH){i_sample[SAMPLE_WIDTH-1]}}, i_sample};
    assign a_ext = {{(CMP_W-AMP_W){1'b0}}, i_amp};
    assign sum   = s_ext + a_ext;
    assign diff  = s_ext - a_ext;
    assign hi    = ~diff[CMP_W-1];
    assign lo    = sum[CMP_W-1] | (sum == '0);

    assign prod  = i_lc * {{(PROD_W-DEN_W){1'b0}}, r_s1_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_hi   <= hi;
            r_s1_lo   <= lo;
            r_s1_sum  <= sum[DEN_W-1:0];
            r_s2.hi   <= r_s1_hi;
            r_s2.lo   <= r_s1_lo;
            r_s2.rem  <= prod[PROD_W-2:LVL_W];
            r_s2.num  <= prod[LVL_W-1:0];
            r_s2.quo  <= '0;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_div   = r_s2;

endmodule

// File: design/pqe_div_stage.sv
// ----------------------------------------------------------------------------
// pqe_div_stage
// One registered slice of the restoring divider, BITS_PER_STAGE quotient bits a slice.
// ----------------------------------------------------------------------------
module pqe_div_stage
    import pqe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  t_div             i_div,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_valid,
    output t_div             o_div
);

    t_div             nxt;
    logic             r_valid;
    t_div             r_div;

    always_comb begin
        logic [DEN_W:0] t;
        logic           ge;
        nxt = i_div;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            t       = {nxt.rem, nxt.num[LVL_W-1]};
            ge      = (t >= {1'b0, i_den});
            nxt.rem = ge ? DEN_W'(t - {1'b0, i_den}) : t[DEN_W-1:0];
            nxt.quo = {nxt.quo[LVL_W-2:0], ge};
            nxt.num = {nxt.num[LVL_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_div <= nxt;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

// File: design/pqe_serial.sv
// ----------------------------------------------------------------------------
// pqe_serial
// Shifts the level out MSB first, one bit a cycle, marking the final bit.
// ----------------------------------------------------------------------------
module pqe_serial
    import pqe_pkg::*;
#(
    parameter int MAX_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic [LVL_W-1:0]                        i_level,
    input  logic [((MAX_BITS > 1) ? $clog2(MAX_BITS) : 1)-1:0] i_nb_m1,
    output logic                                    o_take,
    output logic                                    o_strobe,
    output logic                                    o_pcm_bit,
    output logic [LVL_W-1:0]                        o_level,
    output logic                                    o_last_bit
);

    localparam int POS_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int EXT_W = (MAX_BITS > LVL_W) ? MAX_BITS : LVL_W;

    logic             r_act;
    logic [POS_W-1:0] r_pos;
    logic [LVL_W-1:0] r_lvl;
    logic             at_end;
    logic [EXT_W-1:0] shifted;

    assign at_end = (r_pos == '0);
    assign o_take = ~r_act | at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_valid && o_take) begin
            r_act <= 1'b1;
        end else if (r_act && at_end) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_take) begin
            r_pos <= i_nb_m1;
            r_lvl <= i_level;
        end else if (r_act && !at_end) begin
            r_pos <= r_pos - 1'b1;
        end
    end

    assign shifted    = {{(EXT_W-LVL_W){1'b0}}, r_lvl} >> r_pos;
    assign o_strobe   = r_act;
    assign o_pcm_bit  = shifted[0];
    assign o_level    = r_lvl;
    assign o_last_bit = at_end;

endmodule

// File: design/pcm_quantize_encode.sv
// ----------------------------------------------------------------------------
// pcm_quantize_encode
// A taken request passes the range check, scaling and divider registers; the
// first bit of its word is on the outputs once the serialiser takes the word.
// Words are bit_count bits long (clamped to 1..MAX_BITS), sent one bit a cycle
// by the serialiser; the six-stage pipeline stalls as one while it waits for it.
// The output cannot be held off. Synchronous reset clears all valid state
// and restores amplitude 32767, 256 levels and 8 bits per word.
// ----------------------------------------------------------------------------
module pcm_quantize_encode
    import pqe_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_BITS     = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DAT_W-1:0]    i_cfg_data,
    output logic                    o_strobe,
    output logic                    o_pcm_bit,
    output logic [LVL_W-1:0]        o_level,
    output logic                    o_last_bit
);

    localparam int POS_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

    logic [AMP_W-1:0] r_amplitude;
    logic [LC_W-1:0]  r_level_count;
    logic [BC_W-1:0]  r_bit_count;

    logic [AMP_W-1:0] amp_eff;
    logic [LC_W-1:0]  lc_eff;
    logic [LVL_W-1:0] lc_m1;
    logic [DEN_W-1:0] den;
    logic [5:0]       nb;
    logic [POS_W-1:0] nb_m1;

    logic             adv;
    logic             take;
    logic             div_valid [DIV_STAGES+1];
    t_div             div_data  [DIV_STAGES+1];
    logic [LVL_W-1:0] level_in;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude   <= AMP_RESET;
            r_level_count <= LC_RESET;
            r_bit_count   <= BC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_AMPLITUDE:   r_amplitude   <= i_cfg_data[AMP_W-1:0];
                CFG_LEVEL_COUNT: r_level_count <= i_cfg_data[LC_W-1:0];
                CFG_BIT_COUNT:   r_bit_count   <= i_cfg_data[BC_W-1:0];
                default: ;
            endcase
        end
    end

    // effective settings
    always_comb begin
        amp_eff = (r_amplitude == '0) ? AMP_W'(1) : r_amplitude;
        if (r_level_count < LC_MIN) begin
            lc_eff = LC_MIN;
        end else if (r_level_count > LC_MAX) begin
            lc_eff = LC_MAX;
        end else begin
            lc_eff = r_level_count;
        end
        lc_m1 = LVL_W'(lc_eff - 1'b1);
        den   = {amp_eff, 1'b0};
        if (r_bit_count == '0) begin
            nb = 6'd1;
        end else if ({1'b0, r_bit_count} > 6'(MAX_BITS)) begin
            nb = 6'(MAX_BITS);
        end else begin
            nb = {1'b0, r_bit_count};
        end
        nb_m1 = POS_W'(nb - 1'b1);
    end

    assign adv  = ~div_valid[DIV_STAGES] | take;
    assign busy = ~adv;

    pqe_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (start),
        .i_sample (i_sample),
        .i_amp    (amp_eff),
        .i_lc     (lc_eff),
        .o_valid  (div_valid[0]),
        .o_div    (div_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        pqe_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (div_valid[g]),
            .i_div   (div_data[g]),
            .i_den   (den),
            .o_valid (div_valid[g+1]),
            .o_div   (div_data[g+1])
        );
    end

    always_comb begin
        if (div_data[DIV_STAGES].hi) begin
            level_in = lc_m1;
        end else if (div_data[DIV_STAGES].lo) begin
            level_in = '0;
        end else begin
            level_in = div_data[DIV_STAGES].quo;
        end
    end

    pqe_serial #(
        .MAX_BITS (MAX_BITS)
    ) u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (div_valid[DIV_STAGES]),
        .i_level    (level_in),
        .i_nb_m1    (nb_m1),
        .o_take     (take),
        .o_strobe   (o_strobe),
        .o_pcm_bit  (o_pcm_bit),
        .o_level    (o_level),
        .o_last_bit (o_last_bit)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the uniform PCM quantiser and serial encoder.
// A clocked driver takes samples and register writes from a pending queue,
// predicts each serial word as the sample is taken and queues its bits; a
// clocked monitor compares every strobed bit with the oldest queued one.
// Directed corner cases come first, then three phases of random settings and
// samples, the sender holding back a waiting sample 37, 84 and 0 percent of the time.
// ----------------------------------------------------------------------------
module testbench
    import pqe_pkg::*;
();

    localparam int SAMPLE_W    = 16;
    localparam int MAX_BITS    = 16;
    localparam int DRAIN       = 12;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_ITEMS = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic             pcm_bit;
        logic [LVL_W-1:0] level;
        logic             last_bit;
    } t_pcm_bit;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        logic [SAMPLE_W-1:0]  sample;
        int unsigned          gap_pct;
    } t_request;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;
    logic                  o_strobe;
    logic                  o_pcm_bit;
    logic [LVL_W-1:0]      o_level;
    logic                  o_last_bit;

    t_request    requests[$];
    t_pcm_bit    pcm_bits_due[$];

    logic [AMP_W-1:0] amp_q;
    logic [LC_W-1:0]  levels_q;
    logic [BC_W-1:0]  word_bits_q;

    int unsigned gap_pct = 37;
    int          gen_amp = 32767;
    int          quiet_cycles = 0;
    int          idle_cycles = 0;
    bit          timed_out = 1'b0;
    int          n_fail = 0;
    int          n_samples = 0;
    int          n_writes = 0;
    int          n_bits = 0;

    pcm_quantize_encode #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .MAX_BITS     (MAX_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample    (i_sample),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_pcm_bit   (o_pcm_bit),
        .o_level     (o_level),
        .o_last_bit  (o_last_bit)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [LVL_W-1:0] quantize_sample(input logic signed [SAMPLE_W-1:0] smp);
        longint s;
        longint a;
        longint lc;
        s  = smp;
        a  = (amp_q == '0) ? 64'sd1 : longint'(amp_q);
        lc = longint'(levels_q);
        if (lc < 2) lc = 2;
        if (lc > 65536) lc = 65536;
        if (s >= a) return LVL_W'(lc - 1);
        if (s <= -a) return '0;
        return LVL_W'((lc * (s + a)) / (2 * a));
    endfunction

    function automatic void queue_word(input logic [LVL_W-1:0] lvl);
        int nb;
        nb = int'(word_bits_q);
        if (nb == 0) nb = 1;
        if (nb > MAX_BITS) nb = MAX_BITS;
        for (int k = 0; k < nb; k++) begin
            pcm_bits_due.push_back('{pcm_bit: lvl[nb-1-k], level: lvl, last_bit: (k == nb - 1)});
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int a);
        int v;
        case ($urandom_range(5))
            0, 1:    v = $urandom;
            2:       v = a + $urandom_range(2) - 1;
            3:       v = -a + $urandom_range(2) - 1;
            4:       v = $urandom_range(2 * a) - a;
            default: v = $urandom_range(8) - 4;
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic add_sample(input logic [SAMPLE_W-1:0] s);
        requests.push_back('{is_cfg: 1'b0, idx: '0, data: '0, sample: s, gap_pct: gap_pct});
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        requests.push_back('{is_cfg: 1'b1, idx: idx, data: data, sample: '0, gap_pct: gap_pct});
        if (idx == CFG_AMPLITUDE) begin
            gen_amp = int'(data[AMP_W-1:0]);
            if (gen_amp == 0) gen_amp = 1;
        end
    endtask

    task automatic add_random_setting();
        logic [CFG_DAT_W-1:0] amp;
        logic [CFG_DAT_W-1:0] lc;
        logic [CFG_DAT_W-1:0] bc;
        case ($urandom_range(4))
            0:       amp = 17'd1;
            1:       amp = 17'd32767;
            2:       amp = CFG_DAT_W'($urandom_range(32767, 1));
            3:       amp = CFG_DAT_W'($urandom);
            default: amp = CFG_DAT_W'($urandom_range(16, 0));
        endcase
        case ($urandom_range(5))
            0:       lc = 17'd2;
            1:       lc = 17'd65536;
            2:       lc = 17'd1 << $urandom_range(16, 1);
            3:       lc = CFG_DAT_W'($urandom_range(65536, 2));
            4:       lc = CFG_DAT_W'($urandom);
            default: lc = CFG_DAT_W'($urandom_range(300, 2));
        endcase
        if ($urandom_range(5) == 0) bc = CFG_DAT_W'($urandom);
        else bc = CFG_DAT_W'($urandom_range(16, 1));
        add_write(CFG_AMPLITUDE, amp);
        add_write(CFG_LEVEL_COUNT, lc);
        add_write(CFG_BIT_COUNT, bc);
        if ($urandom_range(7) == 0) add_write(CFG_UNUSED, CFG_DAT_W'($urandom));
    endtask

    // driver: samples and register writes from the pending queue
    always @(posedge i_clk) begin : drv
        logic                 nx_start;
        logic [SAMPLE_W-1:0]  nx_sample;
        logic                 nx_cfg_valid;
        logic [CFG_IDX_W-1:0] nx_idx;
        logic [CFG_DAT_W-1:0] nx_data;
        if (!i_rst_n) begin
            amp_q        = AMP_RESET;
            levels_q     = LC_RESET;
            word_bits_q  = BC_RESET;
            quiet_cycles = 0;
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nx_start     = start;
            nx_sample    = i_sample;
            nx_cfg_valid = i_cfg_valid;
            nx_idx       = i_cfg_index;
            nx_data      = i_cfg_data;
            if (start && !busy) begin
                queue_word(quantize_sample(i_sample));
                void'(requests.pop_front());
                n_samples++;
                nx_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AMPLITUDE:   amp_q       = i_cfg_data[AMP_W-1:0];
                    CFG_LEVEL_COUNT: levels_q    = i_cfg_data[LC_W-1:0];
                    CFG_BIT_COUNT:   word_bits_q = i_cfg_data[BC_W-1:0];
                    default: ;
                endcase
                void'(requests.pop_front());
                n_writes++;
                nx_cfg_valid = 1'b0;
            end
            if (pcm_bits_due.size() == 0 && !nx_start) quiet_cycles++;
            else quiet_cycles = 0;
            if (requests.size() != 0 && !nx_start && !nx_cfg_valid) begin
                if (requests[0].is_cfg) begin
                    // registers change only once the last word has drained
                    if (quiet_cycles >= DRAIN) begin
                        nx_cfg_valid = 1'b1;
                        nx_idx       = requests[0].idx;
                        nx_data      = requests[0].data;
                    end
                end else if ($urandom_range(99) >= requests[0].gap_pct) begin
                    nx_start  = 1'b1;
                    nx_sample = requests[0].sample;
                end
            end
            start       <= nx_start;
            i_sample    <= nx_sample;
            i_cfg_valid <= nx_cfg_valid;
            i_cfg_index <= nx_idx;
            i_cfg_data  <= nx_data;
        end
    end

    // monitor: every strobed bit against the oldest predicted one
    always @(posedge i_clk) begin : mon
        t_pcm_bit due;
        if (i_rst_n && o_strobe) begin
            n_bits++;
            if (pcm_bits_due.size() == 0) begin
                $error("unexpected result: pcm_bit %0d level %0d last_bit %0d",
                       o_pcm_bit, o_level, o_last_bit);
                n_fail++;
            end else begin
                due = pcm_bits_due.pop_front();
                if (o_pcm_bit !== due.pcm_bit) begin
                    $error("pcm_bit: expected %0d, got %0d", due.pcm_bit, o_pcm_bit);
                    n_fail++;
                end
                if (o_level !== due.level) begin
                    $error("level: expected %0d, got %0d", due.level, o_level);
                    n_fail++;
                end
                if (o_last_bit !== due.last_bit) begin
                    $error("last_bit: expected %0d, got %0d", due.last_bit, o_last_bit);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles with no request, write or result taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_strobe) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
        end
    end

    initial begin
        int in_phase;
        int chunk;
        int unsigned pcts[3];
        pcts = '{37, 84, 0};

        // directed: reset settings, range ends and bit patterns
        gap_pct = pcts[0];
        add_sample(16'sd32767);
        add_sample(-16'sd32768);
        add_sample(16'sd0);
        add_sample(-16'sd1);
        add_sample(16'sd1);
        add_sample(-16'sd32767);
        add_sample(16'sd32766);
        add_sample(16'h5555);
        add_sample(16'hAAAA);
        // zero amplitude behaves as one
        add_write(CFG_AMPLITUDE, 17'd0);
        add_write(CFG_LEVEL_COUNT, 17'd4);
        add_write(CFG_BIT_COUNT, 17'd3);
        add_sample(16'sd0);
        add_sample(-16'sd1);
        add_sample(16'sd1);
        // upper data bits dropped, one level too few, zero bits per word
        add_write(CFG_AMPLITUDE, 17'h1_0005);
        add_write(CFG_LEVEL_COUNT, 17'd1);
        add_write(CFG_BIT_COUNT, 17'd0);
        add_sample(16'sd4);
        add_sample(-16'sd5);
        add_sample(16'sd5);
        // level count and word size above their maxima
        add_write(CFG_AMPLITUDE, 17'd32767);
        add_write(CFG_LEVEL_COUNT, 17'h1FFFF);
        add_write(CFG_BIT_COUNT, 17'd31);
        add_sample(16'sd32767);
        add_sample(-16'sd32768);
        add_sample(16'sd0);
        add_sample(16'sd12345);
        // unused index ignored, zero level count
        add_write(CFG_UNUSED, 17'h1FFFF);
        add_write(CFG_AMPLITUDE, 17'd1);
        add_write(CFG_LEVEL_COUNT, 17'd0);
        add_write(CFG_BIT_COUNT, 17'd2);
        add_sample(16'sd0);
        add_sample(16'sd1);
        add_sample(-16'sd1);

        for (int p = 0; p < 3; p++) begin
            gap_pct  = pcts[p];
            in_phase = 0;
            while (in_phase < PHASE_ITEMS) begin
                add_random_setting();
                chunk = $urandom_range(30, 15);
                for (int i = 0; i < chunk; i++) add_sample(pick_sample(gen_amp));
                in_phase += chunk;
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out && (requests.size() != 0 || pcm_bits_due.size() != 0
                              || start || i_cfg_valid))
            @(posedge i_clk);

        if (timed_out) begin
            $display("[pcm_quantize_encode] ERROR");
        end else begin
            repeat (2 * DRAIN) @(posedge i_clk);
            if (pcm_bits_due.size() != 0) begin
                $error("%0d predicted bits never arrived", pcm_bits_due.size());
                n_fail++;
            end
            $display("run: %0d samples, %0d register writes, %0d serial bits checked",
                     n_samples, n_writes, n_bits);
            $display("sender gaps 37%%, 84%% then none; %0d mismatches", n_fail);
            if (n_fail == 0) begin
                $display("[pcm_quantize_encode] OK");
            end else begin
                $display("[pcm_quantize_encode] ERROR");
            end
        end
        $finish;
    end

endmodule

// File: sim.f
design/pqe_pkg.sv
design/pqe_front.sv
design/pqe_div_stage.sv
design/pqe_serial.sv
design/pcm_quantize_encode.sv
bench/testbench.sv
